// ===== rtl/lcd_nib_pkg.sv =====
// types, constants and init tables for the character lcd nibble sequencer
`timescale 1ns / 1ps
`default_nettype none
package lcd_nib_pkg;

  typedef enum logic [1:0] {
    REQ_CMD    = 2'd0,
    REQ_DATA   = 2'd1,
    REQ_CURSOR = 2'd2,
    REQ_INIT   = 2'd3
  } req_kind_t;

  localparam logic [7:0] CMD_ROW0     = 8'h80;
  localparam logic [7:0] CMD_ROW1     = 8'hC0;
  localparam logic [5:0] POWER_UP_MS  = 6'd50;
  localparam logic [5:0] EN_HIGH_MS   = 6'd1;
  localparam int         INIT_CMDS    = 10;
  // leading wait plus four phases per init command
  localparam logic [5:0] INIT_LAST_IX = 6'(4 * INIT_CMDS);
  localparam logic [5:0] BYTE_LAST_IX = 6'd3;

  // one decoded request waiting to be expanded into pin phases
  typedef struct packed {
    logic       init;
    logic       rs;
    logic [7:0] value;
  } job_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic       enable;
    logic [5:0] hold_ms;
    logic       last;
  } phase_t;

  function automatic logic [7:0] init_cmd(input logic [3:0] ix);
    logic [7:0] c;
    case (ix)
      4'd0:    c = 8'h03;
      4'd1:    c = 8'h03;
      4'd2:    c = 8'h03;
      4'd3:    c = 8'h02;
      4'd4:    c = 8'h28;
      4'd5:    c = 8'h08;
      4'd6:    c = 8'h01;
      4'd7:    c = 8'h06;
      4'd8:    c = 8'h0C;
      4'd9:    c = 8'h02;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [5:0] init_wait(input logic [3:0] ix);
    logic [5:0] w;
    case (ix)
      4'd0:    w = 6'd5;
      4'd6:    w = 6'd3;
      4'd9:    w = 6'd0;
      4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd7, 4'd8: w = 6'd1;
      default: w = 6'd0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lcd_nib_if.sv =====
// valid/ready channel interfaces for requests and pin phases
`timescale 1ns / 1ps
`default_nettype none
interface lcd_nib_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] byte_value;
  logic [1:0] row;
  logic [4:0] column;

  modport source (output valid, req_type, byte_value, row, column, input ready);
  modport sink (input valid, req_type, byte_value, row, column, output ready);
endinterface

interface lcd_nib_phase_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic [3:0] nibble;
  logic       enable;
  logic [5:0] hold_ms;
  logic       last;

  modport source (output valid, reg_select, nibble, enable, hold_ms, last, input ready);
  modport sink (input valid, reg_select, nibble, enable, hold_ms, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/lcd_nib_decode.sv =====
// request decode: register select, byte to send, cursor address and range check
`timescale 1ns / 1ps
`default_nettype none
module lcd_nib_decode
  import lcd_nib_pkg::*;
#(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 2
) (
  input  wire logic [1:0] req_type,
  input  wire logic [7:0] byte_value,
  input  wire logic [1:0] row,
  input  wire logic [4:0] column,
  output job_t            job,
  output logic            live
);

  logic [7:0] base;
  logic       in_range;

  always_comb begin
    base     = (row == 2'd0) ? CMD_ROW0 : CMD_ROW1;
    in_range = ({1'b0, column} < 6'(COLUMNS)) && ({1'b0, row} < 3'(ROWS)) && (row < 2'd2);
    job.init  = 1'b0;
    job.rs    = 1'b0;
    job.value = byte_value;
    live      = 1'b1;
    case (req_kind_t'(req_type))
      REQ_CMD: begin
        job.rs = 1'b0;
      end
      REQ_DATA: begin
        job.rs = 1'b1;
      end
      REQ_CURSOR: begin
        job.value = base + {3'd0, column};
        live      = in_range;
      end
      REQ_INIT: begin
        job.init = 1'b1;
      end
      default: begin
        live = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/lcd_nib_seq.sv =====
// job register, phase counter, phase generation and output register
`timescale 1ns / 1ps
`default_nettype none
module lcd_nib_seq
  import lcd_nib_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire job_t        in_job,
  input  wire logic        in_live,
  lcd_nib_phase_if.source  phase
);

  logic       job_valid;
  job_t       job;
  logic [5:0] idx;
  logic [5:0] idx_b;
  logic [3:0] cmd;
  logic [1:0] sub;
  logic [7:0] value;
  phase_t     cur;
  logic       out_valid;
  phase_t     out;
  logic       out_load;
  logic       in_accept;

  // work out the phase that the counter points at
  always_comb begin
    idx_b = idx - 6'd1;
    cmd   = idx_b[5:2];
    sub   = job.init ? idx_b[1:0] : idx[1:0];
    value = job.init ? init_cmd(cmd) : job.value;
    cur.reg_select = job.rs;
    cur.nibble     = sub[1] ? value[3:0] : value[7:4];
    cur.enable     = ~sub[0];
    if (!sub[0]) begin
      cur.hold_ms = EN_HIGH_MS;
    end else if (job.init && sub[1]) begin
      cur.hold_ms = init_wait(cmd);
    end else begin
      cur.hold_ms = 6'd0;
    end
    cur.last = job.init ? (idx == INIT_LAST_IX) : (idx == BYTE_LAST_IX);
    if (job.init && idx == 6'd0) begin
      // power-up wait before the first command
      cur.reg_select = 1'b0;
      cur.nibble     = 4'd0;
      cur.enable     = 1'b0;
      cur.hold_ms    = POWER_UP_MS;
    end
  end

  assign out_load  = job_valid && (!out_valid || phase.ready);
  assign in_ready  = !job_valid || (out_load && cur.last);
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      idx       <= 6'd0;
    end else begin
      if (in_accept) begin
        job_valid <= in_live;
        idx       <= 6'd0;
      end else if (out_load) begin
        if (cur.last) begin
          job_valid <= 1'b0;
          idx       <= 6'd0;
        end else begin
          idx <= idx + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      job <= in_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (phase.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out <= cur;
    end
  end

  assign phase.valid      = out_valid;
  assign phase.reg_select = out.reg_select;
  assign phase.nibble     = out.nibble;
  assign phase.enable     = out.enable;
  assign phase.hold_ms    = out.hold_ms;
  assign phase.last       = out.last;

`ifndef NO_ASSERTIONS
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (job.init ? (idx <= INIT_LAST_IX) : (idx <= BYTE_LAST_IX)))
    else $error("phase counter past end of request");

  a_accept_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (in_accept && job_valid) |-> (out_load && cur.last))
    else $error("new request taken while a job still has phases");

  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_load && cur.last) |=> (idx == 6'd0))
    else $error("phase counter not cleared after final phase");

  a_en_high_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out.enable) |-> (out.hold_ms == EN_HIGH_MS && !out.last))
    else $error("enable-high phase with wrong hold or end mark");
`endif

endmodule
`default_nettype wire

// ===== rtl/char_lcd_nibble_sequencer.sv =====
// top level of the 4-bit character lcd nibble sequencer
// the job register holds a request; each phase goes out through the output
// register; throughput: one phase per cycle while the receiver is ready,
// a byte request gives 4 phases, init 41, an out-of-range cursor move none
// reset: rst clears the job and output valid flags, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module char_lcd_nibble_sequencer
  import lcd_nib_pkg::*;
#(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  lcd_nib_req_if.sink     req,
  lcd_nib_phase_if.source phase
);

  job_t job;
  logic live;

  lcd_nib_decode #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_decode (
    .req_type  (req.req_type),
    .byte_value(req.byte_value),
    .row       (req.row),
    .column    (req.column),
    .job       (job),
    .live      (live)
  );

  lcd_nib_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .in_valid(req.valid),
    .in_ready(req.ready),
    .in_job  (job),
    .in_live (live),
    .phase   (phase)
  );

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// self-checking testbench for the 4-bit character lcd nibble sequencer
`timescale 1ns / 1ps
module tb;
  import lcd_nib_pkg::*;

  localparam int LCD_COLUMNS   = 16;
  localparam int LCD_ROWS      = 2;
  localparam int RANDOM_ITEMS  = 190;
  localparam int LONG_HOLD     = 300;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int TAIL_CYCLES   = 20;
  localparam int MAX_PRINTS    = 30;
  // power-up command bytes and the wait after each, first command in the top bits
  localparam logic [79:0] POWER_UP_CMDS  = 80'h03_03_03_02_28_08_01_06_0C_02;
  localparam logic [39:0] POWER_UP_WAITS = 40'h5_1_1_1_1_1_3_1_1_0;

  typedef struct {
    req_kind_t  kind;
    logic [7:0] value;
    logic [1:0] row;
    logic [4:0] column;
    bit         typed;
    bit         silent;
    logic       rs;
    logic [7:0] on_bus;
  } lcd_row_t;

  logic clk;
  logic rst;

  lcd_nib_req_if   req_ch ();
  lcd_nib_phase_if phase_ch ();

  char_lcd_nibble_sequencer #(
    .COLUMNS(LCD_COLUMNS),
    .ROWS   (LCD_ROWS)
  ) u_top (
    .clk  (clk),
    .rst  (rst),
    .req  (req_ch),
    .phase(phase_ch)
  );

  phase_t   pending_phases[$];
  lcd_row_t directed_rows[$];
  int       error_count;
  int       results_seen;
  int       requests_taken;
  int       init_count;
  int       silent_count;
  int       cycle_count;
  bit       long_hold_req;
  bit       hold_active;
  // set by the sender together with the fields it drives
  bit         cur_typed;
  bit         cur_silent;
  logic       cur_rs;
  logic [7:0] cur_on_bus;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pin phases outstanding", cycle_count,
               pending_phases.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < MAX_PRINTS)
      $display("[%0t] mismatch on %s: got %0h, expected %0h (phase %0d)", $realtime, what,
               got, want, results_seen);
    error_count++;
  endtask

  function automatic lcd_row_t mk_row(req_kind_t kind, logic [7:0] value, logic [1:0] row,
                                      logic [4:0] column, bit typed, bit silent, logic rs,
                                      logic [7:0] on_bus);
    lcd_row_t t;
    t.kind   = kind;
    t.value  = value;
    t.row    = row;
    t.column = column;
    t.typed  = typed;
    t.silent = silent;
    t.rs     = rs;
    t.on_bus = on_bus;
    return t;
  endfunction

  task automatic push_byte(input logic rs, input logic [7:0] b, input logic [5:0] tail_hold,
                           input logic is_last);
    pending_phases.push_back('{rs, b[7:4], 1'b1, EN_HIGH_MS, 1'b0});
    pending_phases.push_back('{rs, b[7:4], 1'b0, 6'd0, 1'b0});
    pending_phases.push_back('{rs, b[3:0], 1'b1, EN_HIGH_MS, 1'b0});
    pending_phases.push_back('{rs, b[3:0], 1'b0, tail_hold, is_last});
  endtask

  task automatic expand_request(input req_kind_t kind, input logic [7:0] value,
                                input logic [1:0] r, input logic [4:0] c);
    logic [7:0] addr;
    case (kind)
      REQ_CMD:  push_byte(1'b0, value, 6'd0, 1'b1);
      REQ_DATA: push_byte(1'b1, value, 6'd0, 1'b1);
      REQ_CURSOR: begin
        if (c < LCD_COLUMNS && r < LCD_ROWS && r < 2) begin
          addr = ((r == 2'd0) ? CMD_ROW0 : CMD_ROW1) + 8'(c);
          push_byte(1'b0, addr, 6'd0, 1'b1);
        end else begin
          silent_count++;
        end
      end
      default: begin
        init_count++;
        pending_phases.push_back('{1'b0, 4'h0, 1'b0, POWER_UP_MS, 1'b0});
        for (int i = 0; i < INIT_CMDS; i++)
          push_byte(1'b0, POWER_UP_CMDS[8 * (INIT_CMDS - 1 - i) +: 8],
                    6'(POWER_UP_WAITS[4 * (INIT_CMDS - 1 - i) +: 4]), i == INIT_CMDS - 1);
      end
    endcase
  endtask

  // check results first: a phase taken at this edge never belongs to a request taken now
  always @(posedge clk) begin
    phase_t want;
    if (!rst) begin
      if (phase_ch.valid && phase_ch.ready) begin
        if (pending_phases.size() == 0) begin
          report_mismatch("unexpected phase", {phase_ch.reg_select, phase_ch.nibble}, 0);
        end else begin
          want = pending_phases.pop_front();
          if (phase_ch.reg_select !== want.reg_select)
            report_mismatch("reg_select", phase_ch.reg_select, want.reg_select);
          if (phase_ch.nibble !== want.nibble)
            report_mismatch("nibble", phase_ch.nibble, want.nibble);
          if (phase_ch.enable !== want.enable)
            report_mismatch("enable", phase_ch.enable, want.enable);
          if (phase_ch.hold_ms !== want.hold_ms)
            report_mismatch("hold_ms", phase_ch.hold_ms, want.hold_ms);
          if (phase_ch.last !== want.last)
            report_mismatch("last", phase_ch.last, want.last);
        end
        results_seen++;
      end
      if (req_ch.valid && req_ch.ready) begin
        requests_taken++;
        if (cur_typed && cur_silent)
          silent_count++;
        else if (cur_typed)
          push_byte(cur_rs, cur_on_bus, 6'd0, 1'b1);
        else
          expand_request(req_kind_t'(req_ch.req_type), req_ch.byte_value, req_ch.row,
                         req_ch.column);
      end
    end
  end

  // long receiver stall, counted here so the sender keeps pushing meanwhile
  initial begin
    hold_active = 1'b0;
    wait (long_hold_req);
    @(posedge clk);
    hold_active = 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_active = 1'b0;
  end

  initial begin
    int  seen_local;
    int  countdown;
    bit  sink_burst;
    seen_local = 0;
    countdown  = 0;
    sink_burst = 1'b0;
    phase_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (results_seen != seen_local) begin
        seen_local = results_seen;
        if ($urandom_range(0, 29) == 0) sink_burst = !sink_burst;
        countdown = sink_burst ? 0 : $urandom_range(0, 16);
      end else if (countdown > 0) begin
        countdown--;
      end
      phase_ch.ready <= (countdown == 0) && !hold_active;
    end
  end

  task automatic send_request(input req_kind_t kind, input logic [7:0] value,
                              input logic [1:0] r, input logic [4:0] c, input int gap,
                              input bit typed, input bit silent, input logic rs,
                              input logic [7:0] on_bus);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.byte_value <= value;
    req_ch.row        <= r;
    req_ch.column     <= c;
    cur_typed  = typed;
    cur_silent = silent;
    cur_rs     = rs;
    cur_on_bus = on_bus;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_phases.size() != 0) @(negedge clk);
  endtask

  initial begin
    lcd_row_t   t;
    req_kind_t  kind;
    logic [7:0] value;
    logic [1:0] r;
    logic [4:0] c;
    int         pick;
    int         gap;
    bit         src_burst;

    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_CMD;
    req_ch.byte_value = 8'h00;
    req_ch.row        = 2'd0;
    req_ch.column     = 5'd0;
    cur_typed = 1'b0;
    cur_silent = 1'b0;
    cur_rs = 1'b0;
    cur_on_bus = 8'h00;
    long_hold_req = 1'b0;
    error_count = 0;
    results_seen = 0;
    requests_taken = 0;
    init_count = 0;
    silent_count = 0;
    cycle_count = 0;
    src_burst = 1'b0;

    directed_rows.push_back(mk_row(REQ_CMD, 8'h00, 2'd0, 5'd0, 1, 0, 1'b0, 8'h00));
    directed_rows.push_back(mk_row(REQ_CMD, 8'hFF, 2'd3, 5'd31, 1, 0, 1'b0, 8'hFF));
    directed_rows.push_back(mk_row(REQ_DATA, 8'h00, 2'd3, 5'd31, 1, 0, 1'b1, 8'h00));
    directed_rows.push_back(mk_row(REQ_DATA, 8'hFF, 2'd0, 5'd0, 1, 0, 1'b1, 8'hFF));
    directed_rows.push_back(mk_row(REQ_DATA, 8'hA5, 2'd2, 5'd21, 0, 0, 1'b0, 8'h00));
    directed_rows.push_back(mk_row(REQ_CMD, 8'h5A, 2'd1, 5'd10, 0, 0, 1'b0, 8'h00));
    directed_rows.push_back(mk_row(REQ_CURSOR, 8'h00, 2'd0, 5'd0, 1, 0, 1'b0, 8'h80));
    directed_rows.push_back(mk_row(REQ_CURSOR, 8'hFF, 2'd0, 5'd15, 1, 0, 1'b0, 8'h8F));
    directed_rows.push_back(mk_row(REQ_CURSOR, 8'h00, 2'd1, 5'd0, 1, 0, 1'b0, 8'hC0));
    directed_rows.push_back(mk_row(REQ_CURSOR, 8'hFF, 2'd1, 5'd15, 1, 0, 1'b0, 8'hCF));
    directed_rows.push_back(mk_row(REQ_CURSOR, 8'h3C, 2'd1, 5'd7, 0, 0, 1'b0, 8'h00));
    // cursor positions off the display
    directed_rows.push_back(mk_row(REQ_CURSOR, 8'h00, 2'd2, 5'd3, 1, 1, 1'b0, 8'h00));
    directed_rows.push_back(mk_row(REQ_CURSOR, 8'hFF, 2'd3, 5'd0, 1, 1, 1'b0, 8'h00));
    directed_rows.push_back(mk_row(REQ_CURSOR, 8'h00, 2'd0, 5'd16, 1, 1, 1'b0, 8'h00));
    directed_rows.push_back(mk_row(REQ_CURSOR, 8'hFF, 2'd1, 5'd31, 1, 1, 1'b0, 8'h00));
    directed_rows.push_back(mk_row(REQ_CURSOR, 8'h00, 2'd3, 5'd31, 1, 1, 1'b0, 8'h00));
    directed_rows.push_back(mk_row(REQ_DATA, 8'h41, 2'd0, 5'd0, 0, 0, 1'b0, 8'h00));
    directed_rows.push_back(mk_row(REQ_INIT, 8'hFF, 2'd0, 5'd0, 0, 0, 1'b0, 8'h00));
    directed_rows.push_back(mk_row(REQ_INIT, 8'h00, 2'd3, 5'd31, 0, 0, 1'b0, 8'h00));
    directed_rows.push_back(mk_row(REQ_DATA, 8'h3C, 2'd1, 5'd5, 0, 0, 1'b0, 8'h00));

    wait (!rst);
    foreach (directed_rows[i]) begin
      t = directed_rows[i];
      send_request(t.kind, t.value, t.row, t.column, $urandom_range(0, 3), t.typed, t.silent,
                   t.rs, t.on_bus);
    end
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick  = $urandom_range(0, 99);
      value = 8'($urandom);
      r     = 2'($urandom);
      c     = 5'($urandom);
      if (pick < 35) begin
        kind = REQ_CMD;
      end else if (pick < 70) begin
        kind = REQ_DATA;
      end else if (pick < 95) begin
        kind = REQ_CURSOR;
        if ($urandom_range(0, 3) != 0) begin
          r = 2'($urandom_range(0, LCD_ROWS - 1));
          c = 5'($urandom_range(0, LCD_COLUMNS - 1));
        end
      end else begin
        kind = REQ_INIT;
      end
      // back-to-back requests while the receiver is held off
      if (n == 30) long_hold_req = 1'b1;
      if (n == 100) wait_drained();
      if ($urandom_range(0, 14) == 0) src_burst = !src_burst;
      gap = (src_burst || (n >= 30 && n < 60)) ? 0 : $urandom_range(0, 16);
      send_request(kind, value, r, c, gap, 1'b0, 1'b0, 1'b0, 8'h00);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d requests (%0d power-up sequences, %0d off-screen cursor moves)",
             requests_taken, init_count, silent_count);
    $display("checked %0d pin phases, %0d mismatches", results_seen, error_count);
    if (error_count == 0 && pending_phases.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
